// ===== hw/rtl/tsh_pkg.sv =====
// Package for the transient shaper: widths, fixed-point constants, register
// indexes, payload structs and the controller-to-datapath command struct.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsh_pkg;

	// Fixed sizes of the fields.
	localparam int SAMPLE_BITS  = 24;
	localparam int CHANNELS_DEF = 2;
	localparam int COEFF_W      = 24;
	localparam int ENV_W        = 32;
	localparam int AMT_W        = 16;
	localparam int GAIN_W       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	// Shared multiplier: signed A times signed B.
	localparam int MA_W = 26;
	localparam int MB_W = 33;
	localparam int P_W  = MA_W + MB_W;
	// Intermediate gain width, signed.
	localparam int G_W  = 20;
	// Rounded output sample width before saturation.
	localparam int Y_W  = 33;

	localparam int GAIN_ONE = 8192;
	localparam int GAIN_MIN = 819;
	localparam int GAIN_MAX = 32768;

	localparam logic [COEFF_W:0] COEFF_ONE = (COEFF_W + 1)'(1) << COEFF_W;

	localparam logic [AMT_W-1:0]   ATTACK_RST  = '0;
	localparam logic [AMT_W-1:0]   SUSTAIN_RST = '0;
	localparam logic [COEFF_W-1:0] FAST_RST    = COEFF_W'(16742300);
	localparam logic [COEFF_W-1:0] SLOW_RST    = COEFF_W'(16773721);

	localparam logic signed [P_W-1:0] RND12 = P_W'(1) << 12;
	localparam logic signed [P_W-1:0] RND23 = P_W'(1) << 23;
	localparam logic signed [P_W-1:0] RND30 = P_W'(1) << 30;
	localparam logic signed [P_W-1:0] RND31 = P_W'(1) << 31;

	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_SUSTAIN = 2'd1,
		REG_FAST    = 2'd2,
		REG_SLOW    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		MS_FC_ENV,
		MS_FC_MAG,
		MS_SC_ENV,
		MS_SC_MAG,
		MS_SUS,
		MS_ATK,
		MS_OUT
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic                          channel;
		logic signed [SAMPLE_BITS-1:0] sample_in;
	} tsh_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [GAIN_W-1:0]             gain_applied;
	} tsh_out_t;

	typedef struct packed {
		logic signed [AMT_W-1:0] attack_amount;
		logic signed [AMT_W-1:0] sustain_amount;
		logic [COEFF_W-1:0]      fast_coeff;
		logic [COEFF_W-1:0]      slow_coeff;
	} tsh_cfg_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     st_fast;
		logic     st_slow;
		logic     gain_init;
		logic     gain_add;
		logic     load_out;
	} tsh_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsh_ctrl.sv =====
// Sequencer of the transient shaper: steps the datapath through one
// transaction and owns the input ready and output valid flags.
// Depends on tsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tsh_pkg::tsh_cmd_t      cmd
);
	import tsh_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FAST_ENV,
		ST_FAST_IN,
		ST_SLOW_ENV,
		ST_SLOW_IN,
		ST_ENV_WB,
		ST_SUS_MUL,
		ST_ATK_MUL,
		ST_GAIN_SUM,
		ST_OUT_MUL,
		ST_OUT_WB
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid & in_ready_q;
			end
			ST_FAST_ENV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_FC_ENV;
			end
			ST_FAST_IN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_FC_MAG;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_SLOW_ENV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SC_ENV;
				cmd.acc_op  = ACC_ADD;
			end
			ST_SLOW_IN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SC_MAG;
				cmd.acc_op  = ACC_LOAD;
				cmd.st_fast = 1'b1;
			end
			ST_ENV_WB: begin
				cmd.st_slow = 1'b1;
			end
			ST_SUS_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SUS;
			end
			ST_ATK_MUL: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MS_ATK;
				cmd.gain_init = 1'b1;
			end
			ST_GAIN_SUM: begin
				cmd.gain_add = 1'b1;
			end
			ST_OUT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_OUT;
			end
			ST_OUT_WB: begin
				cmd.load_out = ~out_valid_q | out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load_in) begin
						state_q    <= ST_FAST_ENV;
						in_ready_q <= 1'b0;
					end
				end
				ST_FAST_ENV: state_q <= ST_FAST_IN;
				ST_FAST_IN:  state_q <= ST_SLOW_ENV;
				ST_SLOW_ENV: state_q <= ST_SLOW_IN;
				ST_SLOW_IN:  state_q <= ST_ENV_WB;
				ST_ENV_WB:   state_q <= ST_SUS_MUL;
				ST_SUS_MUL:  state_q <= ST_ATK_MUL;
				ST_ATK_MUL:  state_q <= ST_GAIN_SUM;
				ST_GAIN_SUM: state_q <= ST_OUT_MUL;
				ST_OUT_MUL:  state_q <= ST_OUT_WB;
				ST_OUT_WB: begin
					if (cmd.load_out) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tsh_dp.sv =====
// Datapath of the transient shaper: per-channel envelope state, one shared
// registered multiplier, accumulator, gain clamp and output register.
// Depends on tsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsh_dp #(
	parameter int CHANNELS = tsh_pkg::CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsh_pkg::tsh_cmd_t cmd,
	input  wire tsh_pkg::tsh_cfg_t cfg,
	input  wire tsh_pkg::tsh_in_t  in_data,
	output tsh_pkg::tsh_out_t      out_data
);
	import tsh_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [ENV_W-1:0] fenv_q [CHANNELS];
	logic [ENV_W-1:0] senv_q [CHANNELS];

	logic [CH_W-1:0]               ch_sel;
	logic [CH_W-1:0]               ch_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [ENV_W-1:0]              mag_q;
	logic signed [SAMPLE_BITS:0]   x_ext;
	logic signed [SAMPLE_BITS:0]   x_abs;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  prod_q;
	logic signed [P_W-1:0]  acc_q;
	logic signed [P_W-1:0]  env_sum;
	logic signed [P_W-1:0]  sus_sum;
	logic signed [P_W-1:0]  atk_sum;
	logic signed [P_W-1:0]  y_sum;

	logic [ENV_W-1:0]       fast_q;
	logic [ENV_W-1:0]       slow_q;
	logic signed [ENV_W:0]  trans;
	logic signed [G_W-1:0]  gain_q;
	logic signed [G_W-1:0]  gain_sum;
	logic signed [Y_W-1:0]  y_round;
	tsh_out_t               out_q;

	localparam logic signed [G_W-1:0] GAIN_ONE_G = G_W'(GAIN_ONE);
	localparam logic signed [G_W-1:0] GAIN_MIN_G = G_W'(GAIN_MIN);
	localparam logic signed [G_W-1:0] GAIN_MAX_G = G_W'(GAIN_MAX);

	// Out-of-range channels fold onto the last one.
	assign ch_sel = (int'(in_data.channel) >= CHANNELS) ? CH_W'(CHANNELS - 1)
	                                                    : CH_W'(in_data.channel);
	assign x_ext  = (SAMPLE_BITS + 1)'(in_data.sample_in);
	assign x_abs  = x_ext[SAMPLE_BITS] ? -x_ext : x_ext;

	// Transient, used by the attack product only when positive.
	assign trans = signed'({1'b0, fast_q}) - signed'({1'b0, slow_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MS_FC_ENV: begin
				mul_a = MA_W'({1'b0, cfg.fast_coeff});
				mul_b = MB_W'({1'b0, fenv_q[ch_q]});
			end
			MS_FC_MAG: begin
				mul_a = MA_W'(COEFF_ONE - {1'b0, cfg.fast_coeff});
				mul_b = MB_W'({1'b0, mag_q});
			end
			MS_SC_ENV: begin
				mul_a = MA_W'({1'b0, cfg.slow_coeff});
				mul_b = MB_W'({1'b0, senv_q[ch_q]});
			end
			MS_SC_MAG: begin
				mul_a = MA_W'(COEFF_ONE - {1'b0, cfg.slow_coeff});
				mul_b = MB_W'({1'b0, mag_q});
			end
			MS_SUS: begin
				mul_a = MA_W'(cfg.sustain_amount);
				mul_b = MB_W'({1'b0, slow_q});
			end
			MS_ATK: begin
				mul_a = MA_W'(cfg.attack_amount);
				mul_b = trans[ENV_W] ? '0 : MB_W'(trans);
			end
			MS_OUT: begin
				mul_a = MA_W'(x_q);
				mul_b = MB_W'({1'b0, gain_q[GAIN_W-1:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign env_sum = acc_q + prod_q;
	assign sus_sum = prod_q + RND31;
	assign atk_sum = prod_q + RND30;
	assign y_sum   = prod_q + RND12;
	assign y_round = signed'(y_sum[Y_W+12:13]);

	// Round half up of the two gain terms, then the clamp.
	assign gain_sum = gain_q + signed'(atk_sum[G_W+30:31]);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ch_q  <= ch_sel;
			x_q   <= in_data.sample_in;
			mag_q <= ENV_W'({x_abs[SAMPLE_BITS-1:0], (ENV_W - SAMPLE_BITS)'(0)});
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_q + RND23;
			ACC_ADD:  acc_q <= env_sum;
			ACC_HOLD: acc_q <= acc_q;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.st_fast) begin
			fast_q <= acc_q[ENV_W+23:24];
		end
		if (cmd.st_slow) begin
			slow_q <= env_sum[ENV_W+23:24];
		end
		if (cmd.gain_init) begin
			gain_q <= GAIN_ONE_G + G_W'(signed'(sus_sum[G_W+30:32]));
		end else if (cmd.gain_add) begin
			priority if (gain_sum < GAIN_MIN_G) begin
				gain_q <= GAIN_MIN_G;
			end else if (gain_sum > GAIN_MAX_G) begin
				gain_q <= GAIN_MAX_G;
			end else begin
				gain_q <= gain_sum;
			end
		end
		if (cmd.load_out) begin
			priority if (y_round > Y_MAX) begin
				out_q.sample_out <= SAMPLE_BITS'(Y_MAX);
			end else if (y_round < Y_MIN) begin
				out_q.sample_out <= SAMPLE_BITS'(Y_MIN);
			end else begin
				out_q.sample_out <= SAMPLE_BITS'(y_round);
			end
			out_q.gain_applied <= gain_q[GAIN_W-1:0];
		end
	end

	// Envelope state is written back once both followers have settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				fenv_q[i] <= '0;
				senv_q[i] <= '0;
			end
		end else if (cmd.st_slow) begin
			fenv_q[ch_q] <= fast_q;
			senv_q[ch_q] <= env_sum[ENV_W+23:24];
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/transient_shaper_unit.sv =====
// Transient shaper top level. Each accepted transaction takes seven shared-multiplier
// passes, envelope writeback, gain sum, output load and the idle state that accepts
// the next one; no new input is taken until the current result is loaded, and an
// earlier result still waiting stalls the load.
// Reset (arst_n, asynchronous): envelopes clear to zero, configuration registers take
// their defaults, input ready comes up high and output valid low.
`timescale 1ns / 1ps
`default_nettype none

module transient_shaper_unit #(
	parameter int CHANNELS = tsh_pkg::CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire tsh_pkg::tsh_in_t              in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output tsh_pkg::tsh_out_t                  out_data,
	input  wire logic                          cfg_we,
	input  wire logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsh_pkg::*;

	// The register file. Writes are expected only while no transaction is in
	// flight, so the datapath reads these directly without shadowing.
	tsh_cfg_t cfg_q;
	tsh_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_amount  <= ATTACK_RST;
			cfg_q.sustain_amount <= SUSTAIN_RST;
			cfg_q.fast_coeff     <= FAST_RST;
			cfg_q.slow_coeff     <= SLOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTACK:  cfg_q.attack_amount  <= cfg_data[AMT_W-1:0];
				REG_SUSTAIN: cfg_q.sustain_amount <= cfg_data[AMT_W-1:0];
				REG_FAST:    cfg_q.fast_coeff     <= cfg_data[COEFF_W-1:0];
				REG_SLOW:    cfg_q.slow_coeff     <= cfg_data[COEFF_W-1:0];
				default:     cfg_q                <= cfg_q;
			endcase
		end
	end

	// The controller sequences one transaction at a time; the output register
	// in the datapath lets a finished result wait while the next transaction
	// is accepted and processed.
	tsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds the envelopes of every channel and the one shared
	// multiplier used for both followers, the two gain terms and the output.
	tsh_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// A delivered gain always lies inside the clamp window.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.gain_applied >= GAIN_W'(GAIN_MIN) &&
		               out_data.gain_applied <= GAIN_W'(GAIN_MAX)))
		else $error("gain outside clamp window");

	// Only one transaction is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// A new result appears only at the end of a transaction.
	a_result_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised while idle");
`endif

endmodule

`default_nettype wire
